// File: hdl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII unit.
package b2da_pkg;

  localparam int NUMBER_W   = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int ASCII_W    = 6;

  // ASCII '0' with the upper two bits of the byte removed.
  localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic find;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic idx_zero;
  } dp_sts_t;

endpackage

// File: hdl/binary_to_decimal_ascii_unit.sv
// Top level of the binary to decimal ASCII unit.
// An item is taken when start is high and busy is low. Its low VALUE_BITS bits are
// converted by a shift-and-add-three register that consumes one bit per cycle,
// followed by a step that finds the leading digit.
// The n digits (1 to 10) then appear on consecutive cycles, most significant first,
// each for a single cycle with out_valid high; out_last_digit marks the final one.
// There is no back-pressure: the receiver must take every digit as it is shown.
// A new item is taken only once busy is low again, after the last digit is shown.
// Values of ten digits or more show their low ten.
module binary_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [b2da_pkg::NUMBER_W-1:0] in_number,
  output logic                          out_valid,
  output logic [b2da_pkg::ASCII_W-1:0]  out_ascii_digit,
  output logic                          out_last_digit
);
  import b2da_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  b2da_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk             (clk),
    .in_number       (in_number),
    .cmd             (cmd),
    .sts             (sts),
    .out_ascii_digit (out_ascii_digit),
    .out_last_digit  (out_last_digit)
  );

endmodule

// File: hdl/b2da_ctrl.sv
// Sequencing state machine for the binary to decimal ASCII unit.
module b2da_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  b2da_pkg::dp_sts_t sts,
  output b2da_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import b2da_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.cnt_zero) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        out_valid = 1'b1;
        if (sts.idx_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/b2da_dpath.sv
// Bit-serial double-dabble datapath and digit selection.
module b2da_dpath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic [b2da_pkg::NUMBER_W-1:0] in_number,
  input  b2da_pkg::dp_cmd_t             cmd,
  output b2da_pkg::dp_sts_t             sts,
  output logic [b2da_pkg::ASCII_W-1:0]  out_ascii_digit,
  output logic                          out_last_digit
);
  import b2da_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0]            bin_r, bin_nxt;
  logic [NUM_DIGITS-1:0][3:0]       bcd_r, bcd_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [IDX_W-1:0]                 idx_r, idx_nxt;
  logic [VALUE_BITS-1:0]            load_val;
  logic [NUM_DIGITS-1:0][3:0]       adj;
  logic [BCD_W-1:0]                 adj_flat;
  logic [IDX_W-1:0]                 top_idx;

  generate
    if (VALUE_BITS <= NUMBER_W) begin : g_trunc
      assign load_val = in_number[VALUE_BITS-1:0];
    end else begin : g_ext
      assign load_val = {{(VALUE_BITS - NUMBER_W){1'b0}}, in_number};
    end
  endgenerate

  // Add three to every digit of five or more before the doubling shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    adj_flat = adj;
  end

  // Highest non-zero digit; once the value has passed ten digits all ten are shown.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
    if (ovf_r) begin
      top_idx = IDX_W'(NUM_DIGITS - 1);
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    ovf_nxt = ovf_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (cmd.load) begin
      bin_nxt = load_val;
      bcd_nxt = '0;
      ovf_nxt = 1'b0;
      cnt_nxt = CNT_W'(VALUE_BITS - 1);
    end else if (cmd.shift) begin
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt = {adj_flat[BCD_W-2:0], bin_r[VALUE_BITS-1]};
      ovf_nxt = ovf_r | adj_flat[BCD_W-1];
      cnt_nxt = cnt_r - 1'b1;
    end else if (cmd.find) begin
      idx_nxt = top_idx;
    end else if (cmd.emit) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    ovf_r <= ovf_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
  end

  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.idx_zero   = (idx_r == '0);
  assign out_ascii_digit = ASCII_ZERO + {2'b00, bcd_r[idx_r]};
  assign out_last_digit  = (idx_r == '0);

endmodule

// File: hdl/b2da_checker.sv
// Port-level checks for the binary to decimal ASCII unit, bound to the top level.
module b2da_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [b2da_pkg::ASCII_W-1:0] out_ascii_digit,
  input logic                         out_last_digit
);

  // A digit is only ever shown while an item is being worked on.
  a_valid_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("digit shown while idle");

  a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // The digits of one item come out without gaps.
  a_run_gapless : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_digit) |=> out_valid)
    else $error("gap inside a digit run");

  a_last_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_digit) |=> !busy)
    else $error("still busy after the last digit");

  a_digit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ascii_digit >= 6'd48 && out_ascii_digit <= 6'd57))
    else $error("character is not a decimal digit");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_ascii_digit (out_ascii_digit),
  .out_last_digit  (out_last_digit)
);
